// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

	localparam int SBOX_DEPTH = 256;
	localparam int BYTE_W     = 8;
	localparam int KEY_CNT_W  = 9;
	localparam logic [KEY_CNT_W-1:0] KEY_MAX = 9'd256;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NO_KEY = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [BYTE_W-1:0] byte_value;
		logic              key_last;
	} rc4_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [BYTE_W-1:0] keystream_byte;
		logic              status;
	} rc4_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_W1,
		ST_KS_W2,
		ST_G_J,
		ST_G_W1,
		ST_G_W2,
		ST_G_OUT
	} rc4_state_t;

endpackage

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a read of the address being written returns the new data
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rc4_add.sv =====
module rc4_add (
	input  logic [rc4_pkg::BYTE_W-1:0] a,
	input  logic [rc4_pkg::BYTE_W-1:0] b,
	input  logic [rc4_pkg::BYTE_W-1:0] c,
	output logic [rc4_pkg::BYTE_W-1:0] sum
);

	import rc4_pkg::*;

	// modulo-256 three-operand add
	assign sum = BYTE_W'(a + b + c);

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher. Each input beat carries either a key byte (opcode 0) or
// a data byte (opcode 1). Key bytes are stored in a 256-entry key RAM; bytes
// past KEY_MAX are dropped. A key byte with key_last set starts the key
// schedule, which fills the S-box RAM with the identity and then runs 256
// swap steps, each through ST_KS_RD, ST_KS_J, ST_KS_W1 and ST_KS_W2, with the
// input not ready. The generator indices are cleared at its end. A data byte
// then returns data XOR keystream plus the keystream byte by way of ST_G_J,
// ST_G_W1, ST_G_W2 and ST_G_OUT: the S-box RAM has one read and one write
// port, and each keystream step needs three dependent reads and two writes,
// all through one shared 8-bit adder. A key byte gives no result beat. A data
// byte that arrives before any key schedule has finished comes back unchanged
// with keystream 0 and status 1. The S-box of an old key stays in use until a
// new key's last byte arrives. A finished result waits in an output register;
// a new beat is taken in the idle state once that register is free or being
// emptied. The RAMs need no clearing pass after reset.
module rc4_stream_cipher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rc4_pkg::rc4_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rc4_pkg::rc4_out_t out_data
);

	import rc4_pkg::*;

	rc4_state_t state_q, state_d;

	logic [KEY_CNT_W-1:0] key_count_q;
	logic                 key_ready_q;
	logic [BYTE_W-1:0]    i_q, j_q, k_q, kidx_q;
	logic [BYTE_W-1:0]    si_q, sj_q, data_q;
	logic                 out_valid_q;
	rc4_out_t             out_q;

	// S-box and key RAM ports
	logic              s_we;
	logic [BYTE_W-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
	logic              k_we;
	logic [BYTE_W-1:0] k_rdata;

	// shared adder
	logic [BYTE_W-1:0] add_a, add_b, add_c, add_sum;

	logic in_fire, out_free, out_load, kidx_wrap;

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign k_we      = in_fire && (in_data.opcode == OP_KEY) && (key_count_q < KEY_MAX);
	assign kidx_wrap = ({1'b0, kidx_q} + KEY_CNT_W'(1)) == key_count_q;

	rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (key_count_q[BYTE_W-1:0]),
		.wdata (in_data.byte_value),
		.raddr (kidx_q),
		.rdata (k_rdata)
	);

	rc4_add u_add (
		.a   (add_a),
		.b   (add_b),
		.c   (add_c),
		.sum (add_sum)
	);

	// sequencer: next state, RAM and adder control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		s_we     = 1'b0;
		s_waddr  = k_q;
		s_wdata  = k_q;
		s_raddr  = k_q;
		add_a    = i_q;
		add_b    = BYTE_W'(1);
		add_c    = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				// look up S[i+1] ahead of a data beat
				s_raddr  = add_sum;
				if (in_fire) begin
					if (in_data.opcode == OP_KEY) begin
						if (in_data.key_last) begin
							state_d = ST_INIT;
						end
					end else if (key_ready_q) begin
						state_d = ST_G_J;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ST_INIT: begin
				s_we = 1'b1;
				if (k_q == '1) begin
					state_d = ST_KS_RD;
				end
			end
			ST_KS_RD: begin
				state_d = ST_KS_J;
			end
			ST_KS_J: begin
				add_a   = j_q;
				add_b   = s_rdata;
				add_c   = k_rdata;
				s_raddr = add_sum;
				state_d = ST_KS_W1;
			end
			ST_KS_W1: begin
				s_we    = 1'b1;
				s_wdata = s_rdata;
				state_d = ST_KS_W2;
			end
			ST_KS_W2: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
				state_d = (k_q == '1) ? ST_IDLE : ST_KS_RD;
			end
			ST_G_J: begin
				add_a   = j_q;
				add_b   = s_rdata;
				s_raddr = add_sum;
				state_d = ST_G_W1;
			end
			ST_G_W1: begin
				s_we    = 1'b1;
				s_waddr = i_q;
				s_wdata = s_rdata;
				state_d = ST_G_W2;
			end
			ST_G_W2: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
				add_a   = si_q;
				add_b   = sj_q;
				s_raddr = add_sum;
				state_d = ST_G_OUT;
			end
			ST_G_OUT: begin
				// hold the keystream read address while the output is stalled
				add_a   = si_q;
				add_b   = sj_q;
				s_raddr = add_sum;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			key_ready_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			kidx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.opcode == OP_KEY)) begin
						if (key_count_q < KEY_MAX) begin
							key_count_q <= key_count_q + KEY_CNT_W'(1);
						end
						// keep the old key's generator running until the last byte
						if (in_data.key_last) begin
							k_q    <= '0;
							j_q    <= '0;
							kidx_q <= '0;
						end
					end else if (in_fire && key_ready_q) begin
						i_q <= add_sum;
					end
				end
				ST_INIT: begin
					k_q <= k_q + BYTE_W'(1);
				end
				ST_KS_J, ST_G_J: begin
					j_q <= add_sum;
				end
				ST_KS_W2: begin
					k_q    <= k_q + BYTE_W'(1);
					kidx_q <= kidx_wrap ? '0 : kidx_q + BYTE_W'(1);
					if (k_q == '1) begin
						// schedule done: clear generator, start a fresh key
						i_q         <= '0;
						j_q         <= '0;
						key_ready_q <= 1'b1;
						key_count_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= in_data.byte_value;
		end
		if ((state_q == ST_KS_J) || (state_q == ST_G_J)) begin
			si_q <= s_rdata;
		end
		if (state_q == ST_G_W1) begin
			sj_q <= s_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_IDLE) begin
				out_q.out_byte       <= in_data.byte_value;
				out_q.keystream_byte <= '0;
				out_q.status         <= STATUS_NO_KEY;
			end else begin
				out_q.out_byte       <= data_q ^ s_rdata;
				out_q.keystream_byte <= s_rdata;
				out_q.status         <= STATUS_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a last key byte always launches the schedule
	a_last_starts_sched: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.opcode == OP_KEY) && in_data.key_last |=> state_q == ST_INIT)
		else $error("last key byte did not start the key schedule");

	// data before any key comes back on the next cycle flagged as no-key
	a_nokey_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.opcode == OP_DATA) && !key_ready_q
		|=> out_valid && (out_data.status == STATUS_NO_KEY))
		else $error("no-key data beat not returned at once");

	// an ok status is only possible once a key has been scheduled
	a_ok_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_OK) |-> key_ready_q)
		else $error("keystream result without a scheduled key");

	a_key_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_MAX)
		else $error("key count past maximum");

endmodule
